// ----- src/tpo_pkg.sv -----
// shared widths, register codes and helpers for the triangle pair overlap block
`default_nettype none
package tpo_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = FRAC_BITS + 2;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PNT_W      = COORD_W + 3;
    localparam int ORI_W      = EDGE_W + PNT_W;
    localparam int CR_W       = 2 * COORD_W + 2;
    localparam int HALF_W     = CR_W / 2;
    localparam int PROD_W     = 2 * CR_W;
    localparam int PT_W       = 16;
    localparam int CT_W       = 44;
    localparam int CFG_W      = 44;
    localparam int N_ORI      = 24;
    localparam int IN_W       = 12 * COORD_W;

    localparam logic [PT_W-1:0] PT_RESET = PT_W'(429);
    localparam logic [CT_W-1:0] CT_RESET = CT_W'(64'd1844674407371);

    typedef enum logic {
        CFG_POINT_THR = 1'b0,
        CFG_CROSS_THR = 1'b1
    } t_cfg_idx;

    // sign extend a coordinate to point width
    function automatic logic signed [PNT_W-1:0] ext_pnt(input logic [COORD_W-1:0] v);
        ext_pnt = {{(PNT_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction
endpackage
`default_nettype wire

// ----- src/tpo_below.sv -----
// product of two orientations below minus the crossing threshold, split multiply
`default_nettype none
module tpo_below (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic signed [tpo_pkg::CR_W-1:0] i_u,
    input  wire logic signed [tpo_pkg::CR_W-1:0] i_v,
    input  wire logic [tpo_pkg::CT_W-1:0]       i_thr,
    output logic                                o_below
);
    localparam int HW = tpo_pkg::HALF_W;
    localparam int CW = tpo_pkg::CR_W;
    localparam int PW = tpo_pkg::PROD_W;

    logic [CW-1:0]   mu, mv;
    logic            opp;
    logic            r_opp;
    logic [2*HW-1:0] r_hh, r_hl, r_lh, r_ll;
    logic [PW-1:0]   prod;

    // magnitudes and strict opposite signs
    always_comb begin
        mu  = i_u[CW-1] ? CW'(-i_u) : CW'(i_u);
        mv  = i_v[CW-1] ? CW'(-i_v) : CW'(i_v);
        opp = (i_u != '0) && (i_v != '0) && (i_u[CW-1] != i_v[CW-1]);
    end

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_opp <= opp;
            r_hh  <= mu[CW-1:HW] * mv[CW-1:HW];
            r_hl  <= mu[CW-1:HW] * mv[HW-1:0];
            r_lh  <= mu[HW-1:0] * mv[CW-1:HW];
            r_ll  <= mu[HW-1:0] * mv[HW-1:0];
        end
    end

    // sum partials and compare
    always_comb begin
        prod = {r_hh, {(2*HW){1'b0}}} + {{HW{1'b0}}, r_hl, {HW{1'b0}}}
             + {{HW{1'b0}}, r_lh, {HW{1'b0}}} + {{(2*HW){1'b0}}, r_ll};
        o_below = r_opp && (prod > {{(PW-tpo_pkg::CT_W){1'b0}}, i_thr});
    end
endmodule
`default_nettype wire

// ----- src/triangle_pair_overlap_2d.sv -----
// top level of the two-triangle positive-area overlap test
`default_nettype none
// Accepts one triangle pair per cycle unless stalled and returns one overlap
// flag per pair via stage 1 orientation products, stage 2 orientations,
// stage 3 magnitude partial products and inside tests, stage 4 crossing
// compares and result register. Each stage holds its own valid bit, so bubbles
// close up when the output is stalled. Thresholds must be written through the
// configuration port while no pair is in flight; the block does not enforce it.
module triangle_pair_overlap_2d (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [tpo_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // first_x0, first_y0, first_x1, first_y1, first_x2, first_y2,
    // second_x0, second_y0, second_x1, second_y1, second_x2, second_y2
    input  wire logic [tpo_pkg::IN_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // overlap, then zero fill
    output logic [7:0]                       m_tdata
);
    localparam int CW = tpo_pkg::COORD_W;
    localparam int EW = tpo_pkg::EDGE_W;
    localparam int PW = tpo_pkg::PNT_W;
    localparam int OW = tpo_pkg::ORI_W;
    localparam int NO = tpo_pkg::N_ORI;

    logic [tpo_pkg::PT_W-1:0] r_pt;
    logic [tpo_pkg::CT_W-1:0] r_ct;
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    logic [CW-1:0] fx [3], fy [3], sx [3], sy [3];
    logic signed [OW-1:0] n_pa [NO], n_pb [NO];
    logic signed [OW-1:0] r_pa [NO], r_pb [NO];
    logic signed [OW-1:0] r_o [NO];
    logic n_in, r_in3;
    logic below_f [9], below_s [9];
    logic n_ov, r_ov;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= tpo_pkg::PT_RESET;
            r_ct <= tpo_pkg::CT_RESET;
        end else if (i_cfg_we) begin
            unique case (tpo_pkg::t_cfg_idx'(i_cfg_idx))
                tpo_pkg::CFG_POINT_THR: r_pt <= i_cfg_data[tpo_pkg::PT_W-1:0];
                tpo_pkg::CFG_CROSS_THR: r_ct <= i_cfg_data[tpo_pkg::CT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance chain
    always_comb begin
        adv4 = !r_v4 || m_tready;
        adv3 = !r_v3 || adv4;
        adv2 = !r_v2 || adv3;
        adv1 = !r_v1 || adv2;
        s_tready = adv1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // unpack vertices
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fx[i] = s_tdata[(2*i)*CW +: CW];
            fy[i] = s_tdata[(2*i+1)*CW +: CW];
            sx[i] = s_tdata[(6+2*i)*CW +: CW];
            sy[i] = s_tdata[(7+2*i)*CW +: CW];
        end
    end

    // stage 1 operands: edge deltas times scaled point deltas
    always_comb begin
        logic [CW-1:0] ax, ay, bx, by;
        logic signed [EW-1:0] ex, ey;
        logic signed [PW-1:0] px, py, kax, kay;
        logic signed [PW-1:0] sumfx, sumfy, sumsx, sumsy;
        sumfx = tpo_pkg::ext_pnt(fx[0]) + tpo_pkg::ext_pnt(fx[1]) + tpo_pkg::ext_pnt(fx[2]);
        sumfy = tpo_pkg::ext_pnt(fy[0]) + tpo_pkg::ext_pnt(fy[1]) + tpo_pkg::ext_pnt(fy[2]);
        sumsx = tpo_pkg::ext_pnt(sx[0]) + tpo_pkg::ext_pnt(sx[1]) + tpo_pkg::ext_pnt(sx[2]);
        sumsy = tpo_pkg::ext_pnt(sy[0]) + tpo_pkg::ext_pnt(sy[1]) + tpo_pkg::ext_pnt(sy[2]);
        for (int k = 0; k < NO; k++) begin
            // first edges against second vertices, second edges against first
            // vertices, then both against the other centroid
            if (k < 9) begin
                ax = fx[k/3]; ay = fy[k/3];
                bx = fx[((k/3)+1)%3]; by = fy[((k/3)+1)%3];
                px = tpo_pkg::ext_pnt(sx[k%3]); py = tpo_pkg::ext_pnt(sy[k%3]);
            end else if (k < 18) begin
                ax = sx[(k-9)/3]; ay = sy[(k-9)/3];
                bx = sx[((k-9)/3+1)%3]; by = sy[((k-9)/3+1)%3];
                px = tpo_pkg::ext_pnt(fx[(k-9)%3]); py = tpo_pkg::ext_pnt(fy[(k-9)%3]);
            end else if (k < 21) begin
                ax = fx[k-18]; ay = fy[k-18];
                bx = fx[(k-17)%3]; by = fy[(k-17)%3];
                px = sumsx; py = sumsy;
            end else begin
                ax = sx[k-21]; ay = sy[k-21];
                bx = sx[(k-20)%3]; by = sy[(k-20)%3];
                px = sumfx; py = sumfy;
            end
            if (k < 18) begin
                kax = tpo_pkg::ext_pnt(ax);
                kay = tpo_pkg::ext_pnt(ay);
            end else begin
                kax = tpo_pkg::ext_pnt(ax) + (tpo_pkg::ext_pnt(ax) <<< 1);
                kay = tpo_pkg::ext_pnt(ay) + (tpo_pkg::ext_pnt(ay) <<< 1);
            end
            ex = {bx[CW-1], bx} - {ax[CW-1], ax};
            ey = {by[CW-1], by} - {ay[CW-1], ay};
            n_pa[k] = ex * (py - kay);
            n_pb[k] = ey * (px - kax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && s_tvalid) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
    end

    // stage 2 orientations
    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            for (int k = 0; k < NO; k++) r_o[k] <= r_pa[k] - r_pb[k];
        end
    end

    // stage 3 strict inside tests, either winding
    always_comb begin
        logic signed [OW-1:0] t1, t3;
        logic ok;
        t1 = OW'(r_pt);
        t3 = OW'(r_pt) + (OW'(r_pt) <<< 1);
        n_in = 1'b0;
        for (int p = 0; p < 3; p++) begin
            ok = (r_o[9+p] > t1 && r_o[12+p] > t1 && r_o[15+p] > t1)
              || (r_o[9+p] < -t1 && r_o[12+p] < -t1 && r_o[15+p] < -t1)
              || (r_o[p] > t1 && r_o[3+p] > t1 && r_o[6+p] > t1)
              || (r_o[p] < -t1 && r_o[3+p] < -t1 && r_o[6+p] < -t1);
            n_in = n_in || ok;
        end
        n_in = n_in
            || (r_o[18] > t3 && r_o[19] > t3 && r_o[20] > t3)
            || (r_o[18] < -t3 && r_o[19] < -t3 && r_o[20] < -t3)
            || (r_o[21] > t3 && r_o[22] > t3 && r_o[23] > t3)
            || (r_o[21] < -t3 && r_o[22] < -t3 && r_o[23] < -t3);
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) r_in3 <= n_in;
    end

    // stage 3 crossing products, one pair of units per edge pair
    for (genvar i = 0; i < 3; i++) begin : g_fe
        for (genvar j = 0; j < 3; j++) begin : g_se
            tpo_below u_bf (
                .i_clk   (i_clk),
                .i_en    (adv3 && r_v2),
                .i_u     (r_o[i*3+j][tpo_pkg::CR_W-1:0]),
                .i_v     (r_o[i*3+(j+1)%3][tpo_pkg::CR_W-1:0]),
                .i_thr   (r_ct),
                .o_below (below_f[i*3+j])
            );
            tpo_below u_bs (
                .i_clk   (i_clk),
                .i_en    (adv3 && r_v2),
                .i_u     (r_o[9+j*3+i][tpo_pkg::CR_W-1:0]),
                .i_v     (r_o[9+j*3+(i+1)%3][tpo_pkg::CR_W-1:0]),
                .i_thr   (r_ct),
                .o_below (below_s[i*3+j])
            );
        end
    end

    // stage 4 result
    always_comb begin
        n_ov = r_in3;
        for (int q = 0; q < 9; q++) n_ov = n_ov || (below_f[q] && below_s[q]);
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && r_v3) r_ov <= n_ov;
    end

    assign m_tvalid = r_v4;
    assign m_tdata  = {7'b0, r_ov};

`ifndef SYNTHESIS
    a_take_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_v1)
        else $error("accepted request did not enter stage 1");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !m_tready) |-> !s_tready)
        else $error("ready high with full stalled pipeline");
    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !m_tready) |=> (r_v4 && $stable(r_ov)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// ----- sim/triangle_pair_overlap_2d_tb.sv -----
// testbench for the triangle pair overlap block: directed and random pairs against a predictor
`default_nettype none
module triangle_pair_overlap_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 4;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;
    localparam int CW  = tpo_pkg::COORD_W;
    localparam int IW  = tpo_pkg::IN_W;
    localparam int CFW = tpo_pkg::CFG_W;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_idx = 1'b0;
    logic [CFW-1:0]      i_cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IW-1:0]       s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;

    // predictor copy of the thresholds
    longint unsigned pnt_thr = 429;
    longint unsigned crs_thr = 64'd1844674407371;

    bit  overlap_q[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    int  hold_cnt = 0;
    int  rx_wait = 0;
    int  rx_draw = 0;

    triangle_pair_overlap_2d uut (.*);

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // orientation of point p (scaled by k) against edge a-b
    function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py, longint k);
        return (bx - ax) * (py - k * ay) - (by - ay) * (px - k * ax);
    endfunction

    function automatic bit inside_tri(longint t[6], longint px, longint py, longint k);
        longint thr, o0, o1, o2;
        thr = longint'(pnt_thr) * k;
        o0 = orient(t[0], t[1], t[2], t[3], px, py, k);
        o1 = orient(t[2], t[3], t[4], t[5], px, py, k);
        o2 = orient(t[4], t[5], t[0], t[1], px, py, k);
        return (o0 > thr && o1 > thr && o2 > thr) || (o0 < -thr && o1 < -thr && o2 < -thr);
    endfunction

    // product of opposite-sign orientations below minus crossing threshold
    function automatic bit opposite_strong(longint u, longint v);
        longint unsigned mu, mv;
        if (!((u > 0 && v < 0) || (u < 0 && v > 0))) return 1'b0;
        mu = u < 0 ? -u : u;
        mv = v < 0 ? -v : v;
        return mu > crs_thr / mv;
    endfunction

    function automatic bit pair_overlaps(logic [IW-1:0] d);
        longint f[6], s[6];
        longint ax, ay, bx, by, cx, cy, dx, dy;
        for (int n = 0; n < 6; n++) begin
            f[n] = longint'($signed(d[n*CW +: CW]));
            s[n] = longint'($signed(d[(n+6)*CW +: CW]));
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ax = f[2*i]; ay = f[2*i+1];
                bx = f[2*((i+1)%3)]; by = f[2*((i+1)%3)+1];
                cx = s[2*j]; cy = s[2*j+1];
                dx = s[2*((j+1)%3)]; dy = s[2*((j+1)%3)+1];
                if (opposite_strong(orient(ax, ay, bx, by, cx, cy, 1),
                                    orient(ax, ay, bx, by, dx, dy, 1)) &&
                    opposite_strong(orient(cx, cy, dx, dy, ax, ay, 1),
                                    orient(cx, cy, dx, dy, bx, by, 1)))
                    return 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
            if (inside_tri(s, f[2*i], f[2*i+1], 1)) return 1'b1;
        for (int i = 0; i < 3; i++)
            if (inside_tri(f, s[2*i], s[2*i+1], 1)) return 1'b1;
        if (inside_tri(s, f[0] + f[2] + f[4], f[1] + f[3] + f[5], 3)) return 1'b1;
        return inside_tri(f, s[0] + s[2] + s[4], s[1] + s[3] + s[5], 3);
    endfunction

    // send one pair and queue its expected flag
    task automatic send_pair(logic [IW-1:0] d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        overlap_q.insert(overlap_q.size(), pair_overlaps(d));
    endtask

    function automatic logic [IW-1:0] pack_pair(longint v[12]);
        logic [IW-1:0] d;
        for (int n = 0; n < 12; n++) d[n*CW +: CW] = CW'(v[n]);
        return d;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(tpo_pkg::t_cfg_idx idx, longint unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFW'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == tpo_pkg::CFG_POINT_THR) pnt_thr = val & 64'hFFFF;
        else crs_thr = val & 64'hFFF_FFFF_FFFF;
        @(posedge i_clk);
    endtask

    // random coordinate, mostly small so geometry stays interesting
    function automatic longint rand_coord(int sel);
        unique case (sel)
            0: return longint'($signed(CW'($urandom)));
            1: return $urandom_range(0, 1) ? 131071 : -131072;
            default: return longint'($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    task automatic random_pairs(int count);
        longint v[12];
        int sel;
        for (int c = 0; c < count; c++) begin
            sel = $urandom_range(0, 9);
            sel = sel < 2 ? 0 : (sel == 2 ? 1 : 2);
            for (int n = 0; n < 12; n++) v[n] = rand_coord(sel);
            // nearby second triangle: the first with each coordinate jittered
            if ($urandom_range(0, 2) == 0)
                for (int n = 6; n < 12; n++) v[n] = v[n-6] + $urandom_range(0, 800) - 400;
            send_pair(pack_pair(v), c % 100 < 20);
        end
    endtask

    task automatic test_directed();
        longint v[12];
        // overlapping identical triangles
        v = '{0, 0, 40000, 0, 0, 40000, 0, 0, 40000, 0, 0, 40000};
        send_pair(pack_pair(v));
        // far apart
        v = '{0, 0, 100, 0, 0, 100, 50000, 50000, 50100, 50000, 50000, 50100};
        send_pair(pack_pair(v));
        // touching at a shared edge only
        v = '{0, 0, 40000, 0, 0, 40000, 40000, 0, 0, 40000, 40000, 40000};
        send_pair(pack_pair(v));
        // small inside large, opposite winding
        v = '{-100000, -100000, 100000, -100000, 0, 100000, 10, 10, 0, 500, 500, 10};
        send_pair(pack_pair(v));
        // star of david crossing
        v = '{0, 60000, -52000, -30000, 52000, -30000, 0, -60000, 52000, 30000, -52000, 30000};
        send_pair(pack_pair(v));
        // degenerate first triangle crossing the second
        v = '{-50000, 0, 50000, 0, 0, 0, 0, -40000, 40000, 40000, -40000, 40000};
        send_pair(pack_pair(v));
        // extremes of the field range
        v = '{-131072, -131072, 131071, -131072, -131072, 131071,
              131071, 131071, -131072, 131071, 131071, -131072};
        send_pair(pack_pair(v));
        v = '{131071, 131071, 131071, 131071, 131071, 131071,
              -131072, -131072, -131072, -131072, -131072, -131072};
        send_pair(pack_pair(v));
        v = '{-1, -1, 1, -1, 0, 1, 0, 0, 0, 0, 0, 0};
        send_pair(pack_pair(v));
        drain();
    endtask

    task automatic test_thresholds();
        write_reg(tpo_pkg::CFG_POINT_THR, 0);
        write_reg(tpo_pkg::CFG_CROSS_THR, 0);
        random_pairs(150);
        drain();
        write_reg(tpo_pkg::CFG_POINT_THR, 65535);
        write_reg(tpo_pkg::CFG_CROSS_THR, 64'hFFF_FFFF_FFFF);
        random_pairs(150);
        drain();
        write_reg(tpo_pkg::CFG_POINT_THR, $urandom_range(0, 65535));
        write_reg(tpo_pkg::CFG_CROSS_THR, {$urandom, $urandom});
        random_pairs(150);
        drain();
        write_reg(tpo_pkg::CFG_POINT_THR, 429);
        write_reg(tpo_pkg::CFG_CROSS_THR, 64'd1844674407371);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        random_pairs(60);
        hold_off = 1'b0;
        drain();
    endtask

    // receiver: one long hold-off counted here, else a random wait per result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (hold_off && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else if (m_tvalid && m_tready) begin
            rx_draw = $urandom_range(0, 5);
            m_tready <= (rx_draw == 0);
            rx_wait  <= (rx_draw == 0) ? 0 : rx_draw - 1;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (overlap_q.size() == 0) begin
                $display("%0t: unexpected result overlap=%0b", $realtime, m_tdata[0]);
                errors++;
            end else begin
                if (m_tdata[0] !== overlap_q[0] || m_tdata[7:1] !== '0) begin
                    $display("%0t: overlap mismatch expected %0b actual %0b (tdata %h)",
                             $realtime, overlap_q[0], m_tdata[0], m_tdata);
                    errors++;
                end
                void'(overlap_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("triangle_pair_overlap_2d_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        random_pairs(300);
        drain();
        test_thresholds();
        test_backpressure();
        random_pairs(500);
        drain();
        if (errors == 0 && overlap_q.size() == 0) begin
            $display("triangle_pair_overlap_2d_tb: PASS");
        end else begin
            $display("triangle_pair_overlap_2d_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
